// ----- rtl/dpfl_pkg.sv -----
// package for the dated price floor lookup
// table geometry, status codes and field widths; no dependencies
package dpfl_pkg;
  localparam int TableDepth = 4096;
  localparam int AddrW = $clog2(TableDepth);
  localparam int CountW = AddrW + 1;
  localparam int KeyW = 23;
  localparam int PriceW = 40;
  localparam int AmountW = 27;
  localparam int ValueW = 50;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_BAD_DATE = 3'd1,
    ST_RANGE = 3'd2,
    ST_NEG = 3'd3,
    ST_LARGE = 3'd4,
    ST_EMPTY = 3'd5,
    ST_NO_EARLIER = 3'd6,
    ST_FULL = 3'd7
  } status_t;

  localparam logic [1:0] REG_YEAR = 2'd0;
  localparam logic [1:0] REG_MONTH = 2'd1;
  localparam logic [1:0] REG_DAY = 2'd2;

  localparam logic [13:0] MinYear = 14'd2009;
  localparam logic [AmountW-1:0] MaxAmount = AmountW'(1000 << 16);

  typedef struct packed {
    logic       cmd;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [PriceW-1:0] price;
    logic [AmountW-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [PriceW-1:0] rate;
    logic [ValueW-1:0] value;
  } out_item_t;

  function automatic logic [KeyW-1:0] make_key(logic [13:0] y, logic [3:0] m, logic [4:0] d);
    make_key = {y, m, d};
  endfunction
endpackage

// ----- rtl/dpfl_if.sv -----
// valid/ready channel interface carrying one payload
// depends on nothing; payload type is given by the user
interface dpfl_if #(parameter type payload_t = logic);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/dpfl_check.sv -----
// query date and amount checks, pure logic
// depends on dpfl_pkg
module dpfl_check
  import dpfl_pkg::*;
(
  input  logic [13:0] year,
  input  logic [6:0]  month,
  input  logic [6:0]  day,
  input  logic [AmountW-1:0] amount,
  input  logic [KeyW-1:0] today,
  output logic [2:0]  status
);
  logic leap;
  logic [4:0] lim;
  logic cal_ok;
  logic [KeyW-1:0] key;
  logic [26:0] cent_prod;
  logic [7:0] cent;
  logic [13:0] cent_rem;

  always_comb begin
    // year / 100 by reciprocal multiplication, exact for 14-bit years
    cent_prod = 27'(year) * 27'd5243;
    cent = cent_prod[26:19];
    cent_rem = year - 14'(cent) * 14'd100;
    leap = ((year[1:0] == 2'b00) && (cent_rem != 14'd0)) ||
           ((cent_rem == 14'd0) && (cent[1:0] == 2'b00));
    unique case (month)
      7'd2: lim = leap ? 5'd29 : 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11: lim = 5'd30;
      default: lim = 5'd31;
    endcase
    cal_ok = (month >= 7'd1) && (month <= 7'd12) && (day >= 7'd1) && (day <= {2'b0, lim});
    key = make_key(year, month[3:0], day[4:0]);
    priority if (!cal_ok) status = ST_BAD_DATE;
    else if (year < MinYear || key > today) status = ST_RANGE;
    else if (amount[AmountW-1]) status = ST_NEG;
    else if (amount > MaxAmount) status = ST_LARGE;
    else status = ST_OK;
  end
endmodule

// ----- rtl/dated_price_floor_lookup.sv -----
// dated price floor lookup: sorted table, binary search, shared multiplier
// depends on dpfl_pkg, dpfl_if and dpfl_check
//
// in: one transaction per insert (cmd 0) or query (cmd 1). out: one result
// transaction for each input. cfg: write enable, index and data set today's date.
// The block holds one item at a time and is not ready until its result is taken
// into the output register.
// A query runs a binary search of one memory read per step, about log2(count)+1
// steps (13 at 4096 entries), then one or two fetches and the multiply states
// MUL_HI and MUL_LO.
// An insert of a new date does the same search, then shifts the upper part of the
// table by one entry, reading each moved entry in SHIFT_RD and writing it in
// SHIFT_WR; an insert of a stored date overwrites its price.
// Reset empties the table (count to zero) and sets today to 2009-01-01; no
// clearing pass is needed since only entries below the count are used.
// A stalled receiver holds the result in the output register; the block takes
// one more item, works it and keeps its result until that register frees.
module dated_price_floor_lookup
  import dpfl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  dpfl_if.sink   in_ch,
  dpfl_if.source out_ch,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [13:0] cfg_data
);
  typedef enum logic [3:0] {
    IDLE, SRCH, SRCH_RD, SRCH_CMP, DECIDE, SHIFT_RD, SHIFT_WR, WRITE,
    FETCH, FETCH_WAIT, FETCH_PREV, PREV_WAIT, MUL_HI, MUL_LO, DONE
  } state_t;

  state_t state;
  logic [13:0] today_year;
  logic [3:0]  today_month;
  logic [4:0]  today_day;
  in_item_t item;
  logic [KeyW-1:0] key;
  logic [CountW-1:0] count, lo, hi, idx;
  logic [2:0] status;
  logic [PriceW-1:0] rate;
  logic [ValueW-1:0] acc;
  logic [ValueW+5:0] prod;
  logic [2:0] chk_status;
  logic out_valid;
  out_item_t out_data;

  logic [KeyW-1:0] key_mem [TableDepth];
  logic [PriceW-1:0] price_mem [TableDepth];
  logic [KeyW-1:0] rd_key;
  logic [PriceW-1:0] rd_price;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic wr_en;
  logic [KeyW-1:0] wr_key;
  logic [PriceW-1:0] wr_price;
  logic [CountW-1:0] mid;
  logic [19:0] mul_b;

  dpfl_check u_check (
    .year(item.year), .month(item.month), .day(item.day), .amount(item.amount),
    .today(make_key(today_year, today_month, today_day)), .status(chk_status)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      price_mem[wr_addr] <= wr_price;
    end
    rd_key <= key_mem[rd_addr];
    rd_price <= price_mem[rd_addr];
  end

  assign mid = lo + ((hi - lo) >> 1);
  assign mul_b = (state == MUL_HI) ? rate[PriceW-1:20] : rate[19:0];
  assign prod = ValueW'(item.amount) * (ValueW+6)'(mul_b);

  always_comb begin
    rd_addr = mid[AddrW-1:0];
    if (state == SHIFT_RD || state == SHIFT_WR) rd_addr = AddrW'(idx - 1'b1);
    if (state == FETCH || state == FETCH_WAIT || state == FETCH_PREV || state == PREV_WAIT)
      rd_addr = idx[AddrW-1:0];
    wr_en = (state == SHIFT_WR) || (state == WRITE);
    wr_addr = idx[AddrW-1:0];
    wr_key = (state == WRITE) ? key : rd_key;
    wr_price = (state == WRITE) ? item.price : rd_price;
  end

  assign in_ch.ready = (state == IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      out_valid <= 1'b0;
      today_year <= 14'd2009;
      today_month <= 4'd1;
      today_day <= 5'd1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_YEAR: today_year <= cfg_data;
          REG_MONTH: today_month <= cfg_data[3:0];
          REG_DAY: today_day <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            item <= in_ch.data;
            key <= make_key(in_ch.data.year, in_ch.data.month[3:0], in_ch.data.day[4:0]);
            lo <= '0;
            hi <= count;
            rate <= '0;
            acc <= '0;
            state <= SRCH;
          end
        end
        SRCH: begin
          if (item.cmd == 1'b0 && (item.month > 7'd12 || item.day > 7'd31)) begin
            status <= ST_BAD_DATE;
            state <= DONE;
          end else if (item.cmd == 1'b1 && chk_status != ST_OK) begin
            status <= chk_status;
            state <= DONE;
          end else if (item.cmd == 1'b1 && count == '0) begin
            status <= ST_EMPTY;
            state <= DONE;
          end else if (lo < hi) begin
            state <= SRCH_RD;
          end else begin
            state <= DECIDE;
            idx <= lo;
          end
        end
        SRCH_RD: state <= SRCH_CMP;
        SRCH_CMP: begin
          if (rd_key < key) lo <= mid + 1'b1;
          else hi <= mid;
          state <= SRCH;
        end
        DECIDE: begin
          state <= FETCH;
        end
        FETCH: state <= FETCH_WAIT;
        FETCH_WAIT: begin
          if (idx < count && rd_key == key) begin
            if (item.cmd == 1'b0) begin
              status <= ST_OK;
              rate <= item.price;
              state <= WRITE;
            end else begin
              status <= ST_OK;
              rate <= rd_price;
              state <= MUL_HI;
            end
          end else if (item.cmd == 1'b1) begin
            if (idx == '0) begin
              status <= ST_NO_EARLIER;
              state <= DONE;
            end else begin
              idx <= idx - 1'b1;
              state <= FETCH_PREV;
            end
          end else if (count >= CountW'(TableDepth)) begin
            status <= ST_FULL;
            state <= DONE;
          end else begin
            status <= ST_OK;
            rate <= item.price;
            lo <= idx;
            idx <= count;
            count <= count + 1'b1;
            state <= (count == idx) ? WRITE : SHIFT_RD;
          end
        end
        FETCH_PREV: state <= PREV_WAIT;
        PREV_WAIT: begin
          status <= ST_OK;
          rate <= rd_price;
          state <= MUL_HI;
        end
        SHIFT_RD: state <= SHIFT_WR;
        SHIFT_WR: begin
          idx <= idx - 1'b1;
          state <= (idx - 1'b1 == lo) ? WRITE : SHIFT_RD;
        end
        WRITE: state <= DONE;
        MUL_HI: begin
          acc <= ValueW'(prod << 4);
          state <= MUL_LO;
        end
        MUL_LO: begin
          acc <= acc + ValueW'(prod >> 16);
          state <= DONE;
        end
        DONE: begin
          if (!out_valid) begin
            out_data.status <= status;
            out_data.rate <= (status == ST_OK) ? rate : '0;
            out_data.value <= (status == ST_OK) ? acc : '0;
            out_valid <= 1'b1;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for dated_price_floor_lookup
// uses dpfl_pkg and dpfl_if; a directed table, then random phases
`timescale 1ns / 1ps
module tb_top
  import dpfl_pkg::*;
();

  localparam int Limit = 4000000;
  localparam logic [AmountW-1:0] OneAmt = AmountW'(1 << 16);
  localparam logic [AmountW-1:0] NegAmt = AmountW'(1 << 26);

  typedef struct {
    bit cmd;
    int y;
    int m;
    int d;
    longint price;
    longint amt;
    bit typed;
    status_t st;
    longint rate;
    longint val;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = REG_YEAR;
  logic [13:0] cfg_data = '0;

  dpfl_if #(.payload_t(in_item_t)) in_ch ();
  dpfl_if #(.payload_t(out_item_t)) out_ch ();

  dated_price_floor_lookup i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  logic [KeyW-1:0] price_dates [TableDepth];
  logic [PriceW-1:0] price_table [TableDepth];
  int entries = 0;
  logic [13:0] now_year = 14'd2009;
  logic [3:0] now_month = 4'd1;
  logic [4:0] now_day = 5'd1;
  out_item_t pending_results [$];
  int errors = 0;
  int cycles = 0;
  bit calm = 0;
  bit hold_req = 0;

  row_t dir_rows [22] = '{
    '{1, 2009, 1, 1, 0, OneAmt, 1, ST_EMPTY, 0, 0},
    '{1, 2012, 13, 1, 0, OneAmt, 1, ST_BAD_DATE, 0, 0},
    '{1, 2011, 2, 29, 0, OneAmt, 1, ST_BAD_DATE, 0, 0},
    '{1, 2012, 0, 5, 0, OneAmt, 1, ST_BAD_DATE, 0, 0},
    '{1, 2012, 1, 0, 0, OneAmt, 1, ST_BAD_DATE, 0, 0},
    '{1, 2008, 12, 31, 0, OneAmt, 1, ST_RANGE, 0, 0},
    '{1, 2013, 1, 1, 0, OneAmt, 1, ST_RANGE, 0, 0},
    '{1, 16383, 127, 127, 0, OneAmt, 1, ST_BAD_DATE, 0, 0},
    '{0, 2010, 13, 1, 5, 0, 1, ST_BAD_DATE, 0, 0},
    '{0, 2010, 1, 32, 5, 0, 1, ST_BAD_DATE, 0, 0},
    '{0, 2010, 6, 1, 64'hFF_FFFF_FFFF, 0, 1, ST_OK, 64'hFF_FFFF_FFFF, 0},
    '{1, 2010, 5, 31, 0, OneAmt, 1, ST_NO_EARLIER, 0, 0},
    '{1, 2010, 6, 1, 0, NegAmt, 1, ST_NEG, 0, 0},
    '{1, 2010, 6, 1, 0, MaxAmount + 1, 1, ST_LARGE, 0, 0},
    '{1, 2012, 2, 29, 0, MaxAmount, 0, ST_OK, 0, 0},
    '{1, 2012, 12, 31, 0, 27'h3FF_FFFF, 1, ST_LARGE, 0, 0},
    '{0, 0, 0, 0, 0, 0, 1, ST_OK, 0, 0},
    '{0, 2010, 6, 1, 65536, 0, 1, ST_OK, 65536, 0},
    '{1, 2010, 6, 1, 0, 0, 1, ST_OK, 65536, 0},
    '{1, 2010, 6, 2, 0, 3 << 15, 0, ST_OK, 0, 0},
    '{0, 8999, 12, 31, 123456789, 0, 0, ST_OK, 0, 0},
    '{1, 2009, 1, 1, 0, OneAmt, 0, ST_OK, 0, 0}
  };

  function automatic int first_at_or_after(logic [KeyW-1:0] k);
    int lo, hi, mid;
    lo = 0;
    hi = entries;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (price_dates[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic bit real_date(int y, int m, int d);
    int lim;
    int mdays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m < 1 || m > 12 || d < 1) return 0;
    lim = mdays[m-1];
    if (m == 2 && (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0)) lim = 29;
    return d <= lim;
  endfunction

  function automatic out_item_t price_lookup(in_item_t it);
    out_item_t r;
    logic [KeyW-1:0] k, today;
    logic [63:0] amt, px;
    int pos;
    r = '0;
    k = {it.year, it.month[3:0], it.day[4:0]};
    today = {now_year, now_month, now_day};
    amt = 64'(it.amount);
    pos = first_at_or_after(k);
    if (it.cmd == 1'b0) begin
      if (it.month > 12 || it.day > 31) begin
        r.status = ST_BAD_DATE;
      end else if (pos < entries && price_dates[pos] == k) begin
        price_table[pos] = it.price;
        r.rate = it.price;
      end else if (entries >= TableDepth) begin
        r.status = ST_FULL;
      end else begin
        for (int i = entries; i > pos; i--) begin
          price_dates[i] = price_dates[i-1];
          price_table[i] = price_table[i-1];
        end
        price_dates[pos] = k;
        price_table[pos] = it.price;
        entries++;
        r.rate = it.price;
      end
    end else if (!real_date(it.year, it.month, it.day)) begin
      r.status = ST_BAD_DATE;
    end else if (it.year < MinYear || k > today) begin
      r.status = ST_RANGE;
    end else if (it.amount[AmountW-1]) begin
      r.status = ST_NEG;
    end else if (it.amount > MaxAmount) begin
      r.status = ST_LARGE;
    end else if (entries == 0) begin
      r.status = ST_EMPTY;
    end else if (!(pos < entries && price_dates[pos] == k) && pos == 0) begin
      r.status = ST_NO_EARLIER;
    end else begin
      if (!(pos < entries && price_dates[pos] == k)) pos = pos - 1;
      px = 64'(price_table[pos]);
      r.rate = price_table[pos];
      r.value = ValueW'(((amt * (px >> 20)) << 4) + ((amt * (px & 64'hFFFFF)) >> 16));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        out_item_t e;
        e = pending_results.pop_front();
        if (out_ch.data.status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_ch.data.status);
          errors++;
        end
        if (out_ch.data.rate !== e.rate) begin
          $error("rate: expected %0h actual %0h", e.rate, out_ch.data.rate);
          errors++;
        end
        if (out_ch.data.value !== e.value) begin
          $error("value: expected %0h actual %0h", e.value, out_ch.data.value);
          errors++;
        end
      end
    end
  end

  // receiver side, with a long hold-off on request
  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_ch.ready = 0;
        repeat (400) @(negedge clk);
      end else begin
        out_ch.ready = calm || ($urandom_range(99) >= 38);
      end
    end
  end

  task automatic send(in_item_t it, bit typed, out_item_t e);
    out_item_t p;
    if (!calm && $urandom_range(99) < 38) begin
      in_ch.valid = 0;
      do @(negedge clk); while ($urandom_range(99) < 38);
    end
    in_ch.valid = 1;
    in_ch.data = it;
    do @(posedge clk); while (!in_ch.ready);
    p = price_lookup(it);
    pending_results.push_back(typed ? e : p);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_today(int y, int m, int d);
    int v [3];
    v = '{y, m, d};
    for (int i = 0; i < 3; i++) begin
      cfg_we = 1;
      cfg_index = 2'(i);
      cfg_data = 14'(v[i]);
      @(negedge clk);
    end
    cfg_we = 0;
    now_year = 14'(y);
    now_month = 4'(m);
    now_day = 5'(d);
  endtask

  task automatic random_items(int n, bit wide);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.cmd = ($urandom_range(99) < 60);
      it.year = 14'($urandom_range(2007, 2015));
      it.month = 7'($urandom_range(1, 12));
      it.day = 7'($urandom_range(1, 31));
      if ($urandom_range(9) == 0) it.month = 7'($urandom_range(0, 127));
      if ($urandom_range(9) == 0) it.day = 7'($urandom_range(0, 127));
      if (wide && $urandom_range(7) == 0) it.year = 14'($urandom_range(0, 16383));
      if (it.cmd == 1'b0 && it.year > 8999) it.year = 14'($urandom_range(0, 8999));
      it.price = PriceW'({$urandom, $urandom});
      if ($urandom_range(3) == 0) it.price = PriceW'($urandom_range(0, 1 << 22));
      case ($urandom_range(9))
        0: it.amount = AmountW'($urandom);
        1: it.amount = MaxAmount;
        default: it.amount = AmountW'($urandom_range(0, 1000 << 16));
      endcase
      send(it, 0, '0);
      if (i == n / 3) hold_req = 1;
    end
  endtask

  initial begin
    in_item_t it;
    out_item_t e;
    in_ch.valid = 0;
    in_ch.data = '0;
    repeat (5) @(negedge clk);
    rst = 0;
    set_today(2012, 12, 31);
    foreach (dir_rows[i]) begin
      it.cmd = dir_rows[i].cmd;
      it.year = 14'(dir_rows[i].y);
      it.month = 7'(dir_rows[i].m);
      it.day = 7'(dir_rows[i].d);
      it.price = PriceW'(dir_rows[i].price);
      it.amount = AmountW'(dir_rows[i].amt);
      e.status = dir_rows[i].st;
      e.rate = PriceW'(dir_rows[i].rate);
      e.value = ValueW'(dir_rows[i].val);
      send(it, dir_rows[i].typed, e);
    end
    drain();
    set_today(9999, 12, 31);
    random_items(250, 1);
    drain();
    set_today($urandom_range(2009, 2014), $urandom_range(1, 12), $urandom_range(1, 31));
    calm = 1;
    random_items(80, 0);
    calm = 0;
    random_items(120, 0);
    drain();
    set_today(2009, 1, 1);
    random_items(100, 1);
    drain();
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
